@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/msc_pkg.sv @@
// Package for the min tracking stack: sizes, codes and shared types.
`timescale 1ns / 1ps
package msc_pkg;
  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = 9;
  localparam int OUT_DATA_W  = 48;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;
endpackage

@@ design/min_tracking_stack.sv @@
// Top level of the min tracking stack: counts, min logic and result register.
//
//  channel | dir | ports                        | contents
//  in      | in  | in_tvalid/tready/tdata/tuser | push_value, opcode
//  out     | out | out_tvalid/tready/tdata/tuser| min_value, min_valid, entry_count, status
//
//  One operation per cycle unless the result stalls; the result is registered
//  and appears in the cycle after the transfer. The value row shifts one cell
//  per accepted push or pop; the minima row only when a minimum is pushed or popped.
//  Reset (synchronous, rst_n low) clears both counts and the result valid;
//  cell contents are not reset.
//  A stalled result holds; input is taken while the result register is empty
//  or being drained.
`timescale 1ns / 1ps
module min_tracking_stack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [msc_pkg::WORD_W-1:0]    in_tdata,   // [31:0] push_value
  input  logic [0:0]                    in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [msc_pkg::OUT_DATA_W-1:0] out_tdata, // [31:0] min_value, [32] min_valid,
                                                    // [41:33] entry_count, [47:42] zero
  output logic [msc_pkg::STATUS_W-1:0]  out_tuser   // [1:0] status
);
  import msc_pkg::*;

  localparam count_t DEPTH_C = CNT_W'(STACK_DEPTH);

  count_t     vcount_r, vcount_nxt;
  count_t     mcount_r, mcount_nxt;
  logic       out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]   out_status_r;

  word_t      val_top, val_second;
  word_t      min_top, min_second;
  word_t      push_val, min_cur, min_nxt, min_res;
  shift_ctl_t val_ctl, min_ctl;
  logic       accept, is_pop, full, empty;
  logic       push_ok, pop_ok, push_min, pop_min;
  logic [STATUS_W-1:0] status;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_pop    = (in_tuser[0] == OP_POP);
  assign push_val  = in_tdata;
  assign full      = (vcount_r == DEPTH_C);
  assign empty     = (vcount_r == '0);
  assign min_cur   = (mcount_r != '0) ? min_top : '0;

  always_comb begin
    push_ok  = accept && !is_pop && !full;
    pop_ok   = accept && is_pop && !empty;
    push_min = push_ok && (mcount_r < DEPTH_C) &&
               ((mcount_r == '0) || ($signed(push_val) <= $signed(min_cur)));
    pop_min  = pop_ok && (mcount_r != '0) && (val_top == min_cur);

    val_ctl.push = push_ok;
    val_ctl.pop  = pop_ok;
    min_ctl.push = push_min;
    min_ctl.pop  = pop_min;

    vcount_nxt = vcount_r;
    if (push_ok) begin
      vcount_nxt = vcount_r + count_t'(1);
    end else if (pop_ok) begin
      vcount_nxt = vcount_r - count_t'(1);
    end
    mcount_nxt = mcount_r;
    if (push_min) begin
      mcount_nxt = mcount_r + count_t'(1);
    end else if (pop_min) begin
      mcount_nxt = mcount_r - count_t'(1);
    end

    if (push_min) begin
      min_nxt = push_val;
    end else if (pop_min) begin
      min_nxt = (mcount_nxt != '0) ? min_second : '0;
    end else begin
      min_nxt = min_cur;
    end
    min_res = ((vcount_nxt != '0) && (mcount_nxt != '0)) ? min_nxt : '0;

    if (is_pop && empty) begin
      status = ST_UNDERFLOW;
    end else if (!is_pop && full) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      mcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcount_r <= vcount_nxt;
      mcount_r <= mcount_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_data_r   <= {(OUT_DATA_W - WORD_W - 1 - ENTRY_W)'(0),
                       ENTRY_W'(vcount_nxt),
                       ((vcount_nxt != '0) && (mcount_nxt != '0)),
                       min_res};
    end
  end

  msc_chain u_values (
    .clk       (clk),
    .ctl       (val_ctl),
    .push_word (push_val),
    .top_o     (val_top),
    .second_o  (val_second)
  );

  msc_chain u_minima (
    .clk       (clk),
    .ctl       (min_ctl),
    .push_word (push_val),
    .top_o     (min_top),
    .second_o  (min_second)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
endmodule

@@ design/msc_cell.sv @@
// One stack cell: takes the word above on push, the word below on pop.
`timescale 1ns / 1ps
module msc_cell (
  input  logic               clk,
  input  msc_pkg::shift_ctl_t ctl,
  input  msc_pkg::word_t     above_i,
  input  msc_pkg::word_t     below_i,
  output msc_pkg::word_t     q_o
);
  import msc_pkg::*;

  word_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_r <= above_i;
    end else if (ctl.pop) begin
      q_r <= below_i;
    end
  end

  assign q_o = q_r;
endmodule

@@ design/msc_chain.sv @@
// Row of stack cells; cell 0 is the top of the stack.
`timescale 1ns / 1ps
module msc_chain (
  input  logic                clk,
  input  msc_pkg::shift_ctl_t ctl,
  input  msc_pkg::word_t      push_word,
  output msc_pkg::word_t      top_o,
  output msc_pkg::word_t      second_o
);
  import msc_pkg::*;

  word_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;
    if (i == 0) begin : g_top
      assign above = push_word;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    msc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .above_i (above),
      .below_i (below),
      .q_o     (cell_q[i])
    );
  end

  assign top_o    = cell_q[0];
  assign second_o = cell_q[1];
endmodule

@@ design/msc_checker.sv @@
// Port-level checker for the min tracking stack, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [msc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [msc_pkg::STATUS_W-1:0]   out_tuser
);
  import msc_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `ASSERT_IMPL(a_valid_count, clk, rst_n, out_tvalid,
    out_tdata[32] == (out_tdata[41:33] != 9'd0), "min_valid disagrees with entry_count")
  `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_tvalid && !out_tdata[32],
    out_tdata[31:0] == 32'd0, "empty stack reports nonzero minimum")
  `ASSERT_IMPL(a_overflow_full, clk, rst_n, out_tvalid && (out_tuser == ST_OVERFLOW),
    out_tdata[41:33] == ENTRY_W'(STACK_DEPTH), "overflow while not full")
  `ASSERT_IMPL(a_underflow_empty, clk, rst_n, out_tvalid && (out_tuser == ST_UNDERFLOW),
    (out_tdata[41:33] == 9'd0) && !out_tdata[32], "underflow while not empty")
endmodule

bind min_tracking_stack msc_checker u_msc_checker (.*);
